// ===== hdl/fpa_pkg.sv =====
`default_nettype none

package fpa_pkg;

  // Default number of fractional bits (Q24.8)
  localparam int FRAC_BITS_DEF = 8;

  // Operation codes
  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_LT      = 4'd4,
    OP_GT      = 4'd5,
    OP_LE      = 4'd6,
    OP_GE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } fpa_op_t;

  // Side information that rides along the divider stages
  typedef struct packed {
    logic        is_div;   // item is a divide
    logic        neg;      // quotient must be negated
    logic        dz;       // zero divisor
    logic        cmp;      // comparison outcome
    logic [31:0] value;    // result of every non-divide op
    logic [31:0] divisor;  // divisor magnitude
    logic [31:0] rem;      // partial remainder
  } fpa_carry_t;

endpackage

`default_nettype wire

// ===== hdl/fixed_point_alu_core.sv =====
`default_nettype none

// Signed 32-bit fixed-point ALU with FRAC_BITS fractional bits. Every opcode
// takes the same path, so results leave in order, one beat per cycle when the
// output is not stalled. The divider produces one quotient bit per pipeline
// stage over FRAC_BITS + 32 stages; the front end adds two stages (compare and
// product, then scaling) and the output register one more. When the output
// stalls the whole pipeline holds, and a one-beat skid buffer at the input
// absorbs the beat offered in that cycle. A zero divisor returns 0 with
// divide_by_zero set; overflowing products and quotients wrap to their low 32
// bits.

module fixed_point_alu_core #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         op,
  input  wire logic signed [31:0] operand_a,
  input  wire logic signed [31:0] operand_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      value,
  output logic                    compare_true,
  output logic                    divide_by_zero
);
  import fpa_pkg::*;

  localparam int QW = FRAC_BITS + 32;

  logic               en;
  logic               skid_valid;
  logic [3:0]         skid_op;
  logic signed [31:0] skid_a;
  logic signed [31:0] skid_b;
  logic               feed_valid;
  logic [3:0]         feed_op;
  logic signed [31:0] feed_a;
  logic signed [31:0] feed_b;

  logic               valid_s [0:QW];
  fpa_carry_t         carry_s [0:QW];
  logic [QW-1:0]      quo_s   [0:QW];

  logic [31:0]        quo_low;
  logic [31:0]        final_value;

  // Pipeline advances unless a finished beat is held at the output
  assign en       = !out_valid || !out_stall;
  assign in_stall = skid_valid;

  // Skid buffer: catches the beat offered while the pipeline is frozen
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
    if (!en && in_valid && !skid_valid) begin
      skid_op <= op;
      skid_a  <= operand_a;
      skid_b  <= operand_b;
    end
  end

  assign feed_valid = skid_valid || in_valid;
  assign feed_op    = skid_valid ? skid_op : op;
  assign feed_a     = skid_valid ? skid_a : operand_a;
  assign feed_b     = skid_valid ? skid_b : operand_b;

  fpa_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (feed_valid),
    .in_op     (feed_op),
    .in_a      (feed_a),
    .in_b      (feed_b),
    .out_valid (valid_s[0]),
    .out_carry (carry_s[0]),
    .out_quo   (quo_s[0])
  );

  // Divider: one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_div
    fpa_div_step #(
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (valid_s[i]),
      .in_carry  (carry_s[i]),
      .in_quo    (quo_s[i]),
      .out_valid (valid_s[i+1]),
      .out_carry (carry_s[i+1]),
      .out_quo   (quo_s[i+1])
    );
  end

  // Final result select: signed quotient, zero-divisor override, or passthrough
  always_comb begin
    quo_low = quo_s[QW][31:0];
    if (!carry_s[QW].is_div) begin
      final_value = carry_s[QW].value;
    end else if (carry_s[QW].dz) begin
      final_value = '0;
    end else begin
      final_value = carry_s[QW].neg ? 32'(-quo_low) : quo_low;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_s[QW];
    end
    if (en) begin
      value          <= final_value;
      compare_true   <= carry_s[QW].cmp;
      divide_by_zero <= carry_s[QW].dz;
    end
  end

  // A zero-divisor beat carries a zero value and no compare flag
  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> value == 32'sd0 && !compare_true)
    else $error("divide_by_zero beat with nonzero value or compare flag");

  // Divider leaves a remainder below a nonzero divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    valid_s[QW] && carry_s[QW].is_div && carry_s[QW].divisor != 32'd0
      |-> carry_s[QW].rem < carry_s[QW].divisor)
    else $error("divider remainder not below divisor");

  // Skid buffer fills only while the pipeline is frozen
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(!en))
    else $error("skid buffer filled while pipeline advancing");

endmodule

`default_nettype wire

// ===== hdl/fpa_front.sv =====
`default_nettype none

module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [3:0]               in_op,
  input  wire logic signed [31:0]       in_a,
  input  wire logic signed [31:0]       in_b,
  output logic                          out_valid,
  output fpa_pkg::fpa_carry_t           out_carry,
  output logic [FRAC_BITS+31:0]         out_quo
);
  import fpa_pkg::*;

  fpa_op_t            op_c;
  logic               lt_c;
  logic               eq_c;
  logic signed [31:0] simple_c;
  logic               cmp_c;
  logic signed [63:0] prod_c;
  logic [31:0]        mag_a_c;
  logic [31:0]        mag_b_c;

  // Stage 1 registers
  logic               v1;
  fpa_op_t            op1;
  logic [31:0]        simple1;
  logic               cmp1;
  logic signed [63:0] prod1;
  logic [31:0]        mag_a1;
  logic [31:0]        mag_b1;
  logic               neg1;
  logic               dz1;

  // Stage 1: compare, short arithmetic, full product, divide setup
  always_comb begin
    op_c     = fpa_op_t'(in_op);
    lt_c     = in_a < in_b;
    eq_c     = in_a == in_b;
    simple_c = '0;
    cmp_c    = 1'b0;
    case (op_c)
      OP_ADD:     simple_c = in_a + in_b;
      OP_SUB:     simple_c = in_a - in_b;
      OP_MIN:     simple_c = lt_c ? in_a : in_b;
      OP_MAX:     simple_c = lt_c ? in_b : in_a;
      OP_INC:     simple_c = in_a + 32'sd1;
      OP_DEC:     simple_c = in_a - 32'sd1;
      OP_TOINT:   simple_c = in_a >>> FRAC_BITS;
      OP_FROMINT: simple_c = in_a << FRAC_BITS;
      OP_LT:      cmp_c = lt_c;
      OP_GT:      cmp_c = !lt_c && !eq_c;
      OP_LE:      cmp_c = lt_c || eq_c;
      OP_GE:      cmp_c = !lt_c;
      OP_EQ:      cmp_c = eq_c;
      OP_NE:      cmp_c = !eq_c;
      default:    simple_c = '0;
    endcase
    prod_c  = 64'(in_a) * 64'(in_b);
    mag_a_c = in_a[31] ? 32'(-in_a) : in_a;
    mag_b_c = in_b[31] ? 32'(-in_b) : in_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      op1     <= op_c;
      simple1 <= simple_c;
      cmp1    <= cmp_c;
      prod1   <= prod_c;
      mag_a1  <= mag_a_c;
      mag_b1  <= mag_b_c;
      neg1    <= in_a[31] ^ in_b[31];
      dz1     <= (op_c == OP_DIV) && (in_b == 32'sd0);
    end
  end

  // Stage 2: scale the product, load the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      out_carry.is_div  <= op1 == OP_DIV;
      out_carry.neg     <= neg1;
      out_carry.dz      <= dz1;
      out_carry.cmp     <= cmp1;
      out_carry.value   <= (op1 == OP_MUL) ? prod1[FRAC_BITS +: 32] : simple1;
      out_carry.divisor <= mag_b1;
      out_carry.rem     <= '0;
      out_quo           <= {mag_a1, {FRAC_BITS{1'b0}}};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fpa_div_step.sv =====
`default_nettype none

module fpa_div_step #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire fpa_pkg::fpa_carry_t      in_carry,
  input  wire logic [FRAC_BITS+31:0]    in_quo,
  output logic                          out_valid,
  output fpa_pkg::fpa_carry_t           out_carry,
  output logic [FRAC_BITS+31:0]         out_quo
);
  import fpa_pkg::*;

  localparam int QW = FRAC_BITS + 32;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;
  fpa_carry_t  carry_next;

  // One restoring step: shift in the next dividend bit, try subtracting
  always_comb begin
    trial      = {in_carry.rem, in_quo[QW-1]};
    diff       = trial - {1'b0, in_carry.divisor};
    fits       = trial >= {1'b0, in_carry.divisor};
    carry_next = in_carry;
    carry_next.rem = fits ? diff[31:0] : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_carry <= carry_next;
      out_quo   <= {in_quo[QW-2:0], fits};
    end
  end

endmodule

`default_nettype wire
